// File: rtl/core/y2r_pkg.sv
// ----------------------------------------------------------------------------
// y2r_pkg: shared types and constants of the 4:2:0 YUV to RGB converter
// Holds the chroma term bundle passed from the chroma unit to the pixel lanes,
// the configuration register indexes and the fixed field widths.
// ----------------------------------------------------------------------------
package y2r_pkg;

  // Field widths fixed by the pixel format.
  localparam int SAMPLE_W     = 8;
  localparam int LINE_PAIRS_W = 11;
  localparam int FRAME_ROWS_W = 13;
  localparam int ROW_W        = 12;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_ADDR_W   = 1;

  // Largest effective frame height.
  localparam int MaxFrameRows = 4096;

  // Chroma midpoint.
  localparam logic signed [8:0] CHROMA_MID = 9'sd128;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_LINE_PAIRS = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_ROWS = 1'b1;

  // Chroma contributions shared by both pixels of a pair.
  typedef struct packed {
    logic signed [8:0] red_ofs;    // (3*dV) >> 1
    logic signed [8:0] green_ofs;  // (3*dU + 6*dV) >> 3, subtracted from luma
    logic signed [9:0] blue_ofs;   // (129*dU) >> 6
  } chroma_terms_t;

endpackage

// File: rtl/core/yuv420_to_rgb24_converter.sv
// ----------------------------------------------------------------------------
// yuv420_to_rgb24_converter: 4:2:0 YUV pixel pair to 24-bit RGB converter
// Converts one horizontal pixel pair per request. Even rows store their
// chroma pair in a line store; odd rows reuse the stored pair of that column.
//
//   Channel  Direction  Payload
//   in_      slave      tdata: luma_first, luma_second, chroma_u, chroma_v
//   out_     master     tdata: RGB of both pixels, tlast: end of line,
//                       tuser: end of frame
//   cfg_     write      index 0: line_pairs, index 1: frame_rows
//
// One request per clock is sustained while out_tready stays high. A request passes
// three register stages (line store read, chroma terms, pixel lanes with output
// register); out_tvalid is the valid bit of the output register.
// Each stage holds its request while the next one is full,
// so a bubble anywhere lets in_tready stay high while out_tready is low.
// rst_n clears counters and stage valid bits; the line store is not cleared.
// ----------------------------------------------------------------------------
module yuv420_to_rgb24_converter
  import y2r_pkg::*;
#(
  parameter int MAX_LINE_PAIRS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input pixel pair
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // luma_first, luma_second, chroma_u, chroma_v
  // Output RGB pair
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // red_first, green_first, blue_first,
                                            // red_second, green_second, blue_second
  output logic                  out_tlast,  // end_of_line
  output logic                  out_tuser,  // end_of_frame
  // Configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  localparam int COL_W  = (MAX_LINE_PAIRS > 1) ? $clog2(MAX_LINE_PAIRS) : 1;
  localparam int LIM_W  = $clog2(MAX_LINE_PAIRS + 1);
  localparam int CMP_W  = ((LIM_W > LINE_PAIRS_W) ? LIM_W : LINE_PAIRS_W) + 1;

  // Configuration registers
  logic [LINE_PAIRS_W-1:0] line_pairs_r;
  logic [FRAME_ROWS_W-1:0] frame_rows_r;

  // Position counters
  logic [COL_W-1:0]        col_r;
  logic [COL_W-1:0]        col_nxt;
  logic [ROW_W-1:0]        row_r;
  logic [ROW_W-1:0]        row_nxt;

  // Line store
  logic [2*SAMPLE_W-1:0]   line_mem [MAX_LINE_PAIRS];

  // Handshake chain
  logic in_accept;
  logic rdy1, rdy2, rdy3;

  // Stage 1: request fields and line store read
  logic                  v1_r;
  logic [SAMPLE_W-1:0]   y0_1_r, y1_1_r, u_1_r, v_1_r;
  logic                  odd_1_r, eol_1_r, eof_1_r;
  logic [2*SAMPLE_W-1:0] mem_rd_r;

  // Stage 2: chroma terms
  logic                  v2_r;
  logic [SAMPLE_W-1:0]   y0_2_r, y1_2_r;
  logic                  eol_2_r, eof_2_r;
  chroma_terms_t         terms_2_r;

  // Stage 3: output register
  logic                  v3_r;
  logic [47:0]           rgb_3_r;
  logic                  eol_3_r, eof_3_r;

  logic [CMP_W-1:0]        lp_ext, lp_eff, col_inc;
  logic [FRAME_ROWS_W-1:0] fr_eff, row_inc;
  logic                    eol, eof;
  logic [SAMPLE_W-1:0]     u_sel, v_sel;
  chroma_terms_t           terms;
  logic [SAMPLE_W-1:0]     r0, g0, b0, r1, g1, b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_pairs_r <= LINE_PAIRS_W'(320);
      frame_rows_r <= FRAME_ROWS_W'(480);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_LINE_PAIRS: line_pairs_r <= cfg_wr_data[LINE_PAIRS_W-1:0];
        REG_FRAME_ROWS: frame_rows_r <= cfg_wr_data[FRAME_ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Ready chain: a stage loads when it is empty or its content moves on.
  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign in_accept = in_tvalid && rdy1;

  // Effective line length and frame height, then end-of-line/frame flags.
  always_comb begin
    lp_ext = CMP_W'(line_pairs_r);
    if (lp_ext == '0) begin
      lp_eff = CMP_W'(1);
    end else if (lp_ext > CMP_W'(MAX_LINE_PAIRS)) begin
      lp_eff = CMP_W'(MAX_LINE_PAIRS);
    end else begin
      lp_eff = lp_ext;
    end
    if (frame_rows_r == '0) begin
      fr_eff = FRAME_ROWS_W'(1);
    end else if (frame_rows_r > FRAME_ROWS_W'(MaxFrameRows)) begin
      fr_eff = FRAME_ROWS_W'(MaxFrameRows);
    end else begin
      fr_eff = frame_rows_r;
    end
    col_inc = CMP_W'(col_r) + CMP_W'(1);
    row_inc = FRAME_ROWS_W'(row_r) + FRAME_ROWS_W'(1);
    eol     = col_inc >= lp_eff;
    eof     = eol && (row_inc >= fr_eff);
    if (eol) begin
      col_nxt = '0;
      row_nxt = eof ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = row_r;
    end
  end

  // Position counters advance on each accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line store: even rows write the incoming chroma, odd rows read it back.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (!row_r[0]) begin
        line_mem[col_r] <= {in_tdata[31:24], in_tdata[23:16]};
      end else begin
        mem_rd_r <= line_mem[col_r];
      end
    end
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      y0_1_r  <= in_tdata[7:0];
      y1_1_r  <= in_tdata[15:8];
      u_1_r   <= in_tdata[23:16];
      v_1_r   <= in_tdata[31:24];
      odd_1_r <= row_r[0];
      eol_1_r <= eol;
      eof_1_r <= eof;
    end
  end

  // Chroma source: own pair on even rows, stored pair on odd rows.
  assign u_sel = odd_1_r ? mem_rd_r[SAMPLE_W-1:0] : u_1_r;
  assign v_sel = odd_1_r ? mem_rd_r[2*SAMPLE_W-1:SAMPLE_W] : v_1_r;

  y2r_chroma u_chroma (
    .chroma_u (u_sel),
    .chroma_v (v_sel),
    .terms    (terms)
  );

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      y0_2_r    <= y0_1_r;
      y1_2_r    <= y1_1_r;
      eol_2_r   <= eol_1_r;
      eof_2_r   <= eof_1_r;
      terms_2_r <= terms;
    end
  end

  // Two pixel lanes share the chroma terms of the pair.
  y2r_lane u_lane_first (
    .luma  (y0_2_r),
    .terms (terms_2_r),
    .red   (r0),
    .green (g0),
    .blue  (b0)
  );

  y2r_lane u_lane_second (
    .luma  (y1_2_r),
    .terms (terms_2_r),
    .red   (r1),
    .green (g1),
    .blue  (b1)
  );

  // Stage 3: merge both lanes into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      rgb_3_r <= {b1, g1, r1, b0, g0, r0};
      eol_3_r <= eol_2_r;
      eof_3_r <= eof_2_r;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = rgb_3_r;
  assign out_tlast  = eol_3_r;
  assign out_tuser  = eof_3_r;

endmodule

// File: rtl/core/y2r_chroma.sv
// ----------------------------------------------------------------------------
// y2r_chroma: chroma term unit
// Turns one U/V pair into the red, green and blue offsets with shift-add
// coefficients and arithmetic right shifts.
// ----------------------------------------------------------------------------
module y2r_chroma
  import y2r_pkg::*;
(
  input  logic [SAMPLE_W-1:0] chroma_u,
  input  logic [SAMPLE_W-1:0] chroma_v,
  output chroma_terms_t       terms
);

  logic signed [8:0]  du;
  logic signed [8:0]  dv;
  logic signed [10:0] red_sum;
  logic signed [11:0] green_sum;
  logic signed [16:0] blue_sum;

  // Remove the chroma offset.
  assign du = $signed({1'b0, chroma_u}) - CHROMA_MID;
  assign dv = $signed({1'b0, chroma_v}) - CHROMA_MID;

  // 3*dV, 3*dU + 6*dV and 129*dU as shifts and adds.
  assign red_sum   = (11'(dv) <<< 1) + 11'(dv);
  assign green_sum = (12'(du) <<< 1) + 12'(du) + (12'(dv) <<< 2) + (12'(dv) <<< 1);
  assign blue_sum  = (17'(du) <<< 7) + 17'(du);

  // Floor shifts; the results fit the narrowed widths.
  assign terms.red_ofs   = 9'(red_sum >>> 1);
  assign terms.green_ofs = 9'(green_sum >>> 3);
  assign terms.blue_ofs  = 10'(blue_sum >>> 6);

endmodule

// File: rtl/core/y2r_lane.sv
// ----------------------------------------------------------------------------
// y2r_lane: pixel lane
// Adds the shared red and blue chroma offsets to one luma sample, subtracts the
// green offset, and clamps each color to the 0..255 range.
// ----------------------------------------------------------------------------
module y2r_lane
  import y2r_pkg::*;
(
  input  logic [SAMPLE_W-1:0] luma,
  input  chroma_terms_t       terms,
  output logic [SAMPLE_W-1:0] red,
  output logic [SAMPLE_W-1:0] green,
  output logic [SAMPLE_W-1:0] blue
);

  logic signed [11:0] luma_s;
  logic signed [11:0] red_sum;
  logic signed [11:0] green_sum;
  logic signed [11:0] blue_sum;

  // Saturate a signed sum to an unsigned byte.
  function automatic logic [SAMPLE_W-1:0] clamp8(input logic signed [11:0] x);
    logic [SAMPLE_W-1:0] res;
    if (x < 12'sd0) begin
      res = '0;
    end else if (x > 12'sd255) begin
      res = '1;
    end else begin
      res = x[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  assign luma_s    = $signed({4'b0000, luma});
  assign red_sum   = luma_s + 12'(terms.red_ofs);
  assign green_sum = luma_s - 12'(terms.green_ofs);
  assign blue_sum  = luma_s + 12'(terms.blue_ofs);

  assign red   = clamp8(red_sum);
  assign green = clamp8(green_sum);
  assign blue  = clamp8(blue_sum);

endmodule
